// ----- rtl/wac_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wac_pkg
// shared types and constants of the windowed complex autocorrelation block
// ----------------------------------------------------------------------------
package wac_pkg;

   // default ring depth
   localparam int WIN_MAX_DEF = 64;

   // field widths
   localparam int SAMPLE_W   = 16;
   localparam int IDX_W      = 24;
   localparam int CORR_W     = 18;
   localparam int REQ_W      = 32;
   localparam int RSP_W      = 48;
   localparam int WSIZE_W    = 7;
   localparam int SLIDE_W    = 8;
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 8;

   // fraction bits dropped from the q.28 lag sums
   localparam int FRAC_DROP = 12;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_SIZE = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLIDE_STEP  = 8'd1;

   // register reset values
   localparam logic [WSIZE_W-1:0] WSIZE_RST = 7'd16;
   localparam logic [SLIDE_W-1:0] SLIDE_RST = 8'd1;

   localparam logic [CORR_W-1:0] CORR_MAX = '1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROT,
      ST_MAC,
      ST_FLUSH,
      ST_ABS,
      ST_SQR,
      ST_SQS,
      ST_SQRT,
      ST_DIVL,
      ST_FIN,
      ST_OUT
   } state_type;

   // per-chain cell control
   typedef struct packed {
      logic en;
      logic load;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ----- rtl/windowed_complex_autocorrelation.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_complex_autocorrelation
// mean plain-product autocorrelation magnitude over a sliding sample window
// ----------------------------------------------------------------------------
// Samples enter a row of cells that always holds the newest W samples. When
// a window is due, a second row is loaded as a copy rotated by one place;
// both rows then rotate once per cycle while one complex multiplier pair at
// their heads accumulates the lag sum, and the second row steps one more
// place between lags. Each lag then goes through a one-bit-per-cycle square
// root and divider; a final divide forms the mean. The time that a window
// producing a result takes is set by the per-lag walk of the rows and the
// serial square root and divider. A sample that completes no result is
// taken while the block stays idle. Requests are not accepted during a
// computation; a finished result waits in the output register while the
// next requests are taken.
module windowed_complex_autocorrelation import wac_pkg::*; #(
   parameter int WIN_MAX = WIN_MAX_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_W-1:0]      req_tdata,   // sample_re[15:0], sample_im[31:16]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_W-1:0]           rsp_tdata,   // window_index[23:0], corr_value[41:24]
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int WW    = $clog2(WIN_MAX + 1);
   localparam int ACC_W = 2 * SAMPLE_W + 2 + $clog2(WIN_MAX);
   localparam int AW    = ACC_W - FRAC_DROP;
   localparam int SQ_W  = 2 * AW + 2;
   localparam int MW    = SQ_W / 2;
   localparam int TW    = MW + WW;

   // registers
   logic [WSIZE_W-1:0] wsize_ff;
   logic [SLIDE_W-1:0] slide_ff;
   state_type          state_ff, state_in;
   logic [WW-1:0]      cnt_ff, cnt_in;
   logic [SLIDE_W-1:0] phase_ff, phase_in;
   logic [IDX_W-1:0]   widx_ff, widx_in;
   logic [IDX_W-1:0]   cur_idx_ff, cur_idx_in;
   logic [WW-1:0]      k_ff, k_in;
   logic [WW-1:0]      j_ff, j_in;
   logic               pv_ff;
   logic signed [2*SAMPLE_W-1:0] prr_ff, pii_ff, pri_ff, pir_ff;
   logic signed [ACC_W-1:0]      acc_re_ff, acc_im_ff;
   logic [AW-1:0]      a_ff, b_ff;
   logic [SQ_W-1:0]    sa_ff, sb_ff;
   logic [TW-1:0]      total_ff, total_in;
   logic [CORR_W-1:0]  res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_idx_ff;
   logic [CORR_W-1:0]  rsp_corr_ff;

   // combinational
   logic [WW-1:0]      eff_w;
   logic [SLIDE_W-1:0] slide_eff;
   logic               accept;
   logic [WW-1:0]      cnt_next;
   logic               full;
   logic [SLIDE_W-1:0] ph0;
   logic [SLIDE_W:0]   ph1;
   logic               emit;
   logic               pair_ok;
   logic               out_free;
   logic               acc_clear;
   logic [ACC_W-1:0]   mag_re, mag_im;
   logic signed [2*SAMPLE_W:0] re_term, im_term;

   // units
   logic               sq_start, sq_done;
   logic [MW-1:0]      sq_root;
   logic               dv_start, dv_done;
   logic [TW-1:0]      dv_num, dv_quot;
   logic [WW-1:0]      dv_den;

   // cell rows
   logic [REQ_W-1:0]   win_q [WIN_MAX];
   logic [REQ_W-1:0]   b_q   [WIN_MAX];
   cell_ctrl_type      win_ctrl, b_ctrl;
   logic [REQ_W-1:0]   win_wrap;

   // effective window size and slide
   always_comb begin
      if (wsize_ff < WSIZE_W'(2)) begin
         eff_w = WW'(2);
      end else if (32'(wsize_ff) > 32'(WIN_MAX)) begin
         eff_w = WW'(WIN_MAX);
      end else begin
         eff_w = WW'(wsize_ff);
      end
      slide_eff = (slide_ff == '0) ? SLIDE_W'(1) : slide_ff;
   end

   // request acceptance and window scheduling
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cnt_next = (cnt_ff == WW'(WIN_MAX)) ? cnt_ff : cnt_ff + 1'b1;
      full     = cnt_next >= eff_w;
      ph0      = (phase_ff >= slide_eff) ? '0 : phase_ff;
      ph1      = {1'b0, ph0} + 1'b1;
      emit     = full && (ph0 == '0);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wsize_ff <= WSIZE_RST;
         slide_ff <= SLIDE_RST;
      end else if (csr_we) begin
         if (csr_addr == CSR_WINDOW_SIZE) begin
            wsize_ff <= csr_wdata[WSIZE_W-1:0];
         end
         if (csr_addr == CSR_SLIDE_STEP) begin
            slide_ff <= csr_wdata[SLIDE_W-1:0];
         end
      end
   end

   // row control
   always_comb begin
      win_ctrl.en   = accept || (state_ff == ST_MAC);
      win_ctrl.load = 1'b0;
      win_wrap      = accept ? req_tdata : win_q[0];
      b_ctrl.load   = (state_ff == ST_LOAD);
      b_ctrl.en     = (state_ff == ST_LOAD) || (state_ff == ST_ROT) || (state_ff == ST_MAC);
   end

   for (genvar i = 0; i < WIN_MAX; i++) begin : g_cell
      localparam int NX = (i == WIN_MAX - 1) ? 0 : i + 1;
      logic tail;
      assign tail = (eff_w == WW'(i + 1));

      wac_cell #(.DW(REQ_W)) u_win (
         .clock    (clock),
         .ctrl     (win_ctrl),
         .tail     (tail),
         .load_val (win_q[NX]),
         .next_val (win_q[NX]),
         .wrap_val (win_wrap),
         .q        (win_q[i])
      );

      wac_cell #(.DW(REQ_W)) u_lag (
         .clock    (clock),
         .ctrl     (b_ctrl),
         .tail     (tail),
         .load_val (tail ? win_q[0] : win_q[NX]),
         .next_val (b_q[NX]),
         .wrap_val (b_q[0]),
         .q        (b_q[i])
      );
   end

   // head products
   assign pair_ok = ({1'b0, j_ff} + {1'b0, k_ff}) < {1'b0, eff_w};

   always_ff @(posedge clock) begin
      prr_ff <= $signed(win_q[0][SAMPLE_W-1:0]) * $signed(b_q[0][SAMPLE_W-1:0]);
      pii_ff <= $signed(win_q[0][REQ_W-1:SAMPLE_W]) * $signed(b_q[0][REQ_W-1:SAMPLE_W]);
      pri_ff <= $signed(win_q[0][SAMPLE_W-1:0]) * $signed(b_q[0][REQ_W-1:SAMPLE_W]);
      pir_ff <= $signed(win_q[0][REQ_W-1:SAMPLE_W]) * $signed(b_q[0][SAMPLE_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= (state_ff == ST_MAC) && pair_ok;
      end
   end

   // lag accumulators
   assign acc_clear = (state_ff == ST_LOAD) || (state_ff == ST_ROT);
   assign re_term   = (2*SAMPLE_W+1)'(prr_ff) - (2*SAMPLE_W+1)'(pii_ff);
   assign im_term   = (2*SAMPLE_W+1)'(pri_ff) + (2*SAMPLE_W+1)'(pir_ff);

   always_ff @(posedge clock) begin
      if (acc_clear) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (pv_ff) begin
         acc_re_ff <= acc_re_ff + ACC_W'(re_term);
         acc_im_ff <= acc_im_ff + ACC_W'(im_term);
      end
   end

   // magnitude operands, truncated toward zero
   assign mag_re = acc_re_ff[ACC_W-1] ? ACC_W'(-acc_re_ff) : ACC_W'(acc_re_ff);
   assign mag_im = acc_im_ff[ACC_W-1] ? ACC_W'(-acc_im_ff) : ACC_W'(acc_im_ff);

   always_ff @(posedge clock) begin
      if (state_ff == ST_ABS) begin
         a_ff <= mag_re[ACC_W-1:FRAC_DROP];
         b_ff <= mag_im[ACC_W-1:FRAC_DROP];
      end
      if (state_ff == ST_SQR) begin
         sa_ff <= SQ_W'(a_ff * a_ff);
         sb_ff <= SQ_W'(b_ff * b_ff);
      end
   end

   // shared serial units
   assign sq_start = (state_ff == ST_SQS);

   wac_isqrt #(.IW(SQ_W)) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sa_ff + sb_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   always_comb begin
      dv_start = 1'b0;
      dv_num   = TW'(sq_root);
      dv_den   = eff_w - k_ff;
      if (state_ff == ST_SQRT) begin
         dv_start = sq_done;
      end else if (state_ff == ST_DIVL) begin
         dv_start = dv_done && (k_ff == eff_w - 1'b1);
         dv_num   = total_ff + dv_quot;
         dv_den   = eff_w - 1'b1;
      end
   end

   wac_div #(.NW(TW), .DW(WW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (dv_num),
      .divisor  (dv_den),
      .done     (dv_done),
      .quotient (dv_quot)
   );

   // sequencer
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      widx_in      = widx_ff;
      cur_idx_in   = cur_idx_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      total_in     = total_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in = cnt_next;
               if (full) begin
                  phase_in = (ph1 >= {1'b0, slide_eff}) ? '0 : ph1[SLIDE_W-1:0];
               end
               if (emit) begin
                  cur_idx_in = widx_ff;
                  widx_in    = widx_ff + 1'b1;
                  k_in       = WW'(1);
                  total_in   = '0;
                  state_in   = ST_LOAD;
               end
            end
         end
         ST_LOAD, ST_ROT: begin
            j_in     = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            j_in = j_ff + 1'b1;
            if (j_ff == eff_w - 1'b1) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: state_in = ST_ABS;
         ST_ABS:   state_in = ST_SQR;
         ST_SQR:   state_in = ST_SQS;
         ST_SQS:   state_in = ST_SQRT;
         ST_SQRT: begin
            if (sq_done) begin
               state_in = ST_DIVL;
            end
         end
         ST_DIVL: begin
            if (dv_done) begin
               total_in = total_ff + dv_quot;
               if (k_ff == eff_w - 1'b1) begin
                  state_in = ST_FIN;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_ROT;
               end
            end
         end
         ST_FIN: begin
            if (dv_done) begin
               res_in   = (dv_quot > TW'(CORR_MAX)) ? CORR_MAX : dv_quot[CORR_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // a write to either configuration register restarts the stream
      if (csr_we && (csr_addr == CSR_WINDOW_SIZE || csr_addr == CSR_SLIDE_STEP)) begin
         cnt_in   = '0;
         phase_in = '0;
         widx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         phase_ff     <= '0;
         widx_ff      <= '0;
         k_ff         <= WW'(1);
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         widx_ff      <= widx_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_idx_ff <= cur_idx_in;
      total_ff   <= total_in;
      res_ff     <= res_in;
      if (state_ff == ST_OUT && out_free) begin
         rsp_idx_ff  <= cur_idx_ff;
         rsp_corr_ff <= res_ff;
      end
   end

   // result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W-IDX_W-CORR_W)'(0), rsp_corr_ff, rsp_idx_ff};

   // checks
   a_lag_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (k_ff >= WW'(1) && k_ff < eff_w))
      else $error("lag out of range during computation");

   a_emit_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && emit) |=> (state_ff == ST_LOAD))
      else $error("due window did not start a computation");

   a_mac_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> (j_ff < eff_w))
      else $error("pair counter ran past the window");

   a_pair_source: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> $past(state_ff == ST_MAC))
      else $error("product accumulated outside the pair walk");

endmodule
`default_nettype wire

// ----- rtl/wac_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wac_cell
// one sample cell of a chain: loads, takes its neighbor, or wraps at the tail
// ----------------------------------------------------------------------------
module wac_cell import wac_pkg::*; #(
   parameter int DW = REQ_W
) (
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          tail,
   input  wire logic [DW-1:0] load_val,
   input  wire logic [DW-1:0] next_val,
   input  wire logic [DW-1:0] wrap_val,
   output logic [DW-1:0]      q
);

   logic [DW-1:0] val_ff;
   logic [DW-1:0] val_in;

   // source select
   always_comb begin
      if (ctrl.load) begin
         val_in = load_val;
      end else if (tail) begin
         val_in = wrap_val;
      end else begin
         val_in = next_val;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         val_ff <= val_in;
      end
   end

   assign q = val_ff;

endmodule
`default_nettype wire

// ----- rtl/wac_isqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wac_isqrt
// floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
module wac_isqrt import wac_pkg::*; #(
   parameter int IW = 60
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [IW-1:0]   radicand,
   output logic                 done,
   output logic [IW/2-1:0]      root
);

   localparam logic [IW-1:0] BIT_TOP = {2'b01, {(IW-2){1'b0}}};

   logic [IW-1:0] v_ff, v_in;
   logic [IW-1:0] r_ff, r_in;
   logic [IW-1:0] bit_ff, bit_in;
   logic          done_ff, done_in;
   logic [IW-1:0] trial;

   // one digit step
   always_comb begin
      trial   = r_ff + bit_ff;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      done_in = 1'b0;
      if (start) begin
         v_in   = radicand;
         r_in   = '0;
         bit_in = BIT_TOP;
      end else if (bit_ff != '0) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         done_in = bit_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         bit_ff  <= bit_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign root = r_ff[IW/2-1:0];

endmodule
`default_nettype wire

// ----- rtl/wac_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wac_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wac_div import wac_pkg::*; #(
   parameter int NW = 36,
   parameter int DW = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               done,
   output logic [NW-1:0]      quotient
);

   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] n_ff, n_in;
   logic [DW-1:0] d_ff, d_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic          ge;

   // shift in one dividend bit, subtract when it fits
   always_comb begin
      trial   = {rem_ff, n_ff[NW-1]};
      ge      = trial >= {1'b0, d_ff};
      n_in    = n_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         n_in   = dividend;
         d_in   = divisor;
         rem_in = '0;
         cnt_in = CW'(NW);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? DW'(trial - {1'b0, d_ff}) : DW'(trial);
         n_in    = {n_ff[NW-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = n_ff;

endmodule
`default_nettype wire
